// ===== hw/rtl/radar_target_frame_parser_assert.svh =====
// Assertion macros used by the radar frame parser drain (rtfp_drain).
`ifndef RADAR_TARGET_FRAME_PARSER_ASSERT_SVH
`define RADAR_TARGET_FRAME_PARSER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define RTFP_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked on every edge.
`define RTFP_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rtfp_pkg.sv =====
package rtfp_pkg;

   localparam logic [7:0] HDR0 = 8'hAA;
   localparam logic [7:0] HDR1 = 8'hFF;
   localparam logic [7:0] HDR2 = 8'h03;
   localparam logic [7:0] HDR3 = 8'h00;
   localparam logic [7:0] FTR0 = 8'h55;
   localparam logic [7:0] FTR1 = 8'hCC;
   localparam logic [7:0] MAG_MASK = 8'h7F;
   localparam logic [7:0] SIGN_BIT = 8'h80;

   localparam int SLOT_BASE = 4;
   localparam int SLOT_BYTES = 8;
   localparam int SLOT_BITS = 8 * SLOT_BYTES;
   localparam int INDEX_WIDTH = 2;
   localparam int COUNT_WIDTH = 2;

   typedef struct packed {
      logic                   load;
      logic [COUNT_WIDTH-1:0] count;
   } capture_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] target_index;
      logic [15:0]            pos_x;
      logic [15:0]            pos_y;
      logic [15:0]            velocity;
      logic [15:0]            res_word;
      logic                   present;
      logic [COUNT_WIDTH-1:0] hit_count;
      logic                   last;
   } result_type;

   // The top bit set means positive; a clear top bit negates the magnitude.
   function automatic logic [15:0] decode_sm(input logic [7:0] lo, input logic [7:0] hi);
      logic [15:0] mag;
      mag = {hi & MAG_MASK, lo};
      if ((hi & SIGN_BIT) != 8'h00) begin
         decode_sm = mag;
      end else begin
         decode_sm = (~mag) + 16'd1;
      end
   endfunction

   function automatic logic slot_present(input logic [SLOT_BITS-1:0] slot);
      logic [15:0] x_mag;
      logic [15:0] y_mag;
      x_mag = {slot[15:8] & MAG_MASK, slot[7:0]};
      y_mag = {slot[31:24] & MAG_MASK, slot[23:16]};
      slot_present = (x_mag != 16'd0) || (y_mag != 16'd0);
   endfunction

endpackage

// ===== hw/rtl/radar_target_frame_parser.sv =====
// Timing: a frame's closing byte loads the result buffer; each result then passes through
// the output register before it can be taken.
// Throughput: one byte per cycle and one result per cycle, each unless its stall is high.
// Input stalls only while a decoded frame still waits in the result buffer and the
// next byte could close another frame.
// Reset clears the fresh byte count, the last accept time, the throttle and all valids.
module radar_target_frame_parser #(
   parameter int TARGETS = 3,
   parameter int FRAME_BYTES = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_target_index,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [15:0] rsp_velocity,
   output logic [15:0]        rsp_res_word,
   output logic               rsp_present,
   output logic [1:0]         rsp_hit_count,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_throttle_ms
);

   logic [15:0]                                throttle_ff;
   logic [15:0]                                throttle_in;
   logic                                       busy;
   rtfp_pkg::capture_type                      capture;
   logic [rtfp_pkg::SLOT_BITS*TARGETS-1:0]     slot_bytes;
   rtfp_pkg::result_type                       rsp_result;

   assign csr_ready = 1'b1;
   assign throttle_in = (csr_valid && csr_ready) ? csr_throttle_ms : throttle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         throttle_ff <= '0;
      end else begin
         throttle_ff <= throttle_in;
      end
   end

   rtfp_window #(
      .TARGETS(TARGETS),
      .FRAME_BYTES(FRAME_BYTES)
   ) u_window (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_now_ms(req_now_ms),
      .throttle_ms(throttle_ff),
      .busy(busy),
      .capture(capture),
      .slot_bytes(slot_bytes)
   );

   rtfp_drain #(
      .TARGETS(TARGETS)
   ) u_drain (
      .clock(clock),
      .reset(reset),
      .capture(capture),
      .slot_bytes(slot_bytes),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result(rsp_result)
   );

   assign rsp_target_index = rsp_result.target_index;
   assign rsp_pos_x = $signed(rsp_result.pos_x);
   assign rsp_pos_y = $signed(rsp_result.pos_y);
   assign rsp_velocity = $signed(rsp_result.velocity);
   assign rsp_res_word = rsp_result.res_word;
   assign rsp_present = rsp_result.present;
   assign rsp_hit_count = rsp_result.hit_count;
   assign rsp_last = rsp_result.last;

endmodule

// ===== hw/rtl/rtfp_window.sv =====
module rtfp_window #(
   parameter int TARGETS = 3,
   parameter int FRAME_BYTES = 30
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [7:0]                                req_rx_byte,
   input  logic [31:0]                               req_now_ms,
   input  logic [15:0]                               throttle_ms,
   input  logic                                      busy,
   output rtfp_pkg::capture_type                     capture,
   output logic [rtfp_pkg::SLOT_BITS*TARGETS-1:0]    slot_bytes
);

   localparam int FreshWidth = $clog2(FRAME_BYTES + 1);
   localparam int SlotTotal = rtfp_pkg::SLOT_BYTES * TARGETS;

   logic [7:0]            window_ff [FRAME_BYTES];
   logic [7:0]            window_in [FRAME_BYTES];
   logic [FreshWidth-1:0] fresh_ff;
   logic [FreshWidth-1:0] fresh_in;
   logic [FreshWidth-1:0] fresh_next;
   logic [31:0]           last_ms_ff;
   logic [31:0]           last_ms_in;
   logic [31:0]           elapsed;
   logic                  accept;
   logic                  header_ok;
   logic                  found;
   logic                  drop;
   logic [rtfp_pkg::COUNT_WIDTH-1:0] count;

   assign accept = req_valid && !req_stall;
   assign req_stall = busy && (fresh_ff >= FreshWidth'(FRAME_BYTES - 1));

   for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_shift
      if (i < FRAME_BYTES - 1) begin : g_mid
         assign window_in[i] = window_ff[i+1];
      end else begin : g_end
         assign window_in[i] = req_rx_byte;
      end
   end

   for (genvar j = 0; j < SlotTotal; j++) begin : g_slot
      if (rtfp_pkg::SLOT_BASE + j < FRAME_BYTES) begin : g_in
         assign slot_bytes[8*j +: 8] = window_in[rtfp_pkg::SLOT_BASE + j];
      end else begin : g_out
         assign slot_bytes[8*j +: 8] = 8'h00;
      end
   end

   assign fresh_next = (fresh_ff == FreshWidth'(FRAME_BYTES)) ? fresh_ff
                                                               : fresh_ff + FreshWidth'(1);
   assign header_ok = (window_in[0] == rtfp_pkg::HDR0) && (window_in[1] == rtfp_pkg::HDR1) &&
                      (window_in[2] == rtfp_pkg::HDR2) && (window_in[3] == rtfp_pkg::HDR3) &&
                      (window_in[FRAME_BYTES-2] == rtfp_pkg::FTR0) &&
                      (window_in[FRAME_BYTES-1] == rtfp_pkg::FTR1);
   assign found = accept && (fresh_next == FreshWidth'(FRAME_BYTES)) && header_ok;
   assign elapsed = req_now_ms - last_ms_ff;
   assign drop = (throttle_ms != 16'd0) && (elapsed < {16'd0, throttle_ms});

   always_comb begin
      count = '0;
      for (int t = 0; t < TARGETS; t++) begin
         count = count + rtfp_pkg::COUNT_WIDTH'(
            rtfp_pkg::slot_present(slot_bytes[rtfp_pkg::SLOT_BITS*t +: rtfp_pkg::SLOT_BITS]));
      end
   end

   assign capture.load = found && !drop;
   assign capture.count = count;

   always_comb begin
      fresh_in = fresh_ff;
      if (accept) begin
         fresh_in = found ? '0 : fresh_next;
      end
      last_ms_in = last_ms_ff;
      if (found && !drop && (throttle_ms != 16'd0)) begin
         last_ms_in = req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= '0;
         last_ms_ff <= '0;
      end else begin
         fresh_ff <= fresh_in;
         last_ms_ff <= last_ms_in;
      end
   end

endmodule

// ===== hw/rtl/rtfp_drain.sv =====
`include "radar_target_frame_parser_assert.svh"

module rtfp_drain #(
   parameter int TARGETS = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rtfp_pkg::capture_type                  capture,
   input  logic [rtfp_pkg::SLOT_BITS*TARGETS-1:0] slot_bytes,
   output logic                                   busy,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rtfp_pkg::result_type                   rsp_result
);

   localparam int BufBits = rtfp_pkg::SLOT_BITS * TARGETS;
   localparam int IW = rtfp_pkg::INDEX_WIDTH;
   localparam int CW = rtfp_pkg::COUNT_WIDTH;
   localparam logic [IW-1:0] LastSlot = IW'(TARGETS - 1);

   logic [BufBits-1:0]   buf_ff;
   logic [BufBits-1:0]   buf_in;
   logic                 buf_valid_ff;
   logic                 buf_valid_in;
   logic [IW-1:0]        slot_ff;
   logic [IW-1:0]        slot_in;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rtfp_pkg::result_type rsp_ff;
   rtfp_pkg::result_type rsp_in;
   logic                 load_out;
   logic                 last_slot;
   logic [rtfp_pkg::SLOT_BITS-1:0] head;

   assign head = buf_ff[rtfp_pkg::SLOT_BITS-1:0];
   assign last_slot = (slot_ff == LastSlot);
   assign load_out = buf_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign busy = buf_valid_ff;

   always_comb begin
      rsp_in.target_index = slot_ff;
      rsp_in.pos_x = rtfp_pkg::decode_sm(head[7:0], head[15:8]);
      rsp_in.pos_y = rtfp_pkg::decode_sm(head[23:16], head[31:24]);
      rsp_in.velocity = rtfp_pkg::decode_sm(head[39:32], head[47:40]);
      rsp_in.res_word = {head[63:56], head[55:48]};
      rsp_in.present = rtfp_pkg::slot_present(head);
      rsp_in.hit_count = last_slot ? count_ff : '0;
      rsp_in.last = last_slot;
   end

   always_comb begin
      buf_in = buf_ff;
      buf_valid_in = buf_valid_ff;
      slot_in = slot_ff;
      count_in = count_ff;
      if (capture.load) begin
         buf_in = slot_bytes;
         buf_valid_in = 1'b1;
         slot_in = '0;
         count_in = capture.count;
      end else if (load_out) begin
         buf_in = buf_ff >> rtfp_pkg::SLOT_BITS;
         slot_in = last_slot ? '0 : slot_ff + IW'(1);
         buf_valid_in = !last_slot;
      end
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      count_ff <= count_in;
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         slot_ff <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   `RTFP_ASSERT_RST(a_capture_free, clock, reset, capture.load |-> !buf_valid_ff, "capture while busy")
   `RTFP_ASSERT_RST(a_slot_range, clock, reset, buf_valid_ff |-> slot_ff <= LastSlot, "slot overrun")
   `RTFP_ASSERT_RST(a_last_frees, clock, reset, (load_out && last_slot) |=> !buf_valid_ff, "not freed")
   `RTFP_ASSERT_ALL(a_idle_slot, clock, !buf_valid_ff |-> slot_ff == '0, "slot nonzero while idle")

endmodule

// ===== verif/radar_frame_checker.sv =====
module radar_frame_checker #(
   parameter int TARGETS = 3,
   parameter int FRAME_BYTES = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic [31:0]        req_now_ms,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_target_index,
   input  logic signed [15:0] rsp_pos_x,
   input  logic signed [15:0] rsp_pos_y,
   input  logic signed [15:0] rsp_velocity,
   input  logic [15:0]        rsp_res_word,
   input  logic               rsp_present,
   input  logic [1:0]         rsp_hit_count,
   input  logic               rsp_last,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [15:0]        csr_throttle_ms,
   output int                 errors,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]           byte_window [FRAME_BYTES];
   logic [4:0]           fresh_bytes;
   logic [31:0]          last_accept_ms;
   logic [15:0]          throttle;
   int                   mismatches = 0;
   rtfp_pkg::result_type expected_targets [$];

   function automatic logic [15:0] sm_to_twos(input logic [7:0] lo, input logic [7:0] hi);
      logic [15:0] magnitude;
      magnitude = {1'b0, hi[6:0], lo};
      return hi[7] ? magnitude : 16'd0 - magnitude;
   endfunction

   function automatic logic [7:0] window_byte(input int idx);
      return (idx < FRAME_BYTES) ? byte_window[idx] : 8'h00;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] seen);
      if (want !== seen) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, seen);
         mismatches++;
      end
   endfunction

   task automatic absorb_byte(input logic [7:0] rx, input logic [31:0] now);
      rtfp_pkg::result_type target;
      logic [1:0] present_count;
      int         base;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         byte_window[i] = byte_window[i + 1];
      end
      byte_window[FRAME_BYTES - 1] = rx;
      if (fresh_bytes < FRAME_BYTES) begin
         fresh_bytes++;
      end
      if (fresh_bytes < FRAME_BYTES) begin
         return;
      end
      if (byte_window[0] != rtfp_pkg::HDR0 || byte_window[1] != rtfp_pkg::HDR1 ||
          byte_window[2] != rtfp_pkg::HDR2 || byte_window[3] != rtfp_pkg::HDR3 ||
          byte_window[FRAME_BYTES - 2] != rtfp_pkg::FTR0 ||
          byte_window[FRAME_BYTES - 1] != rtfp_pkg::FTR1) begin
         return;
      end
      fresh_bytes = '0;
      if (throttle != 16'd0) begin
         if (now - last_accept_ms < {16'd0, throttle}) begin
            return;
         end
         last_accept_ms = now;
      end
      present_count = '0;
      for (int i = 0; i < TARGETS; i++) begin
         base = rtfp_pkg::SLOT_BASE + rtfp_pkg::SLOT_BYTES * i;
         target.target_index = 2'(i);
         target.pos_x = sm_to_twos(window_byte(base), window_byte(base + 1));
         target.pos_y = sm_to_twos(window_byte(base + 2), window_byte(base + 3));
         target.velocity = sm_to_twos(window_byte(base + 4), window_byte(base + 5));
         target.res_word = {window_byte(base + 7), window_byte(base + 6)};
         target.present = (target.pos_x != 16'd0) || (target.pos_y != 16'd0);
         present_count = present_count + 2'(target.present);
         target.last = (i == TARGETS - 1);
         target.hit_count = target.last ? present_count : 2'd0;
         expected_targets.push_back(target);
      end
   endtask

   task automatic check_result();
      rtfp_pkg::result_type want;
      if (expected_targets.size() == 0) begin
         $error("unexpected result transaction, target_index %0d", rsp_target_index);
         mismatches++;
      end else begin
         want = expected_targets.pop_front();
         check_field("target_index", 16'(want.target_index), 16'(rsp_target_index));
         check_field("pos_x", want.pos_x, rsp_pos_x);
         check_field("pos_y", want.pos_y, rsp_pos_y);
         check_field("velocity", want.velocity, rsp_velocity);
         check_field("res_word", want.res_word, rsp_res_word);
         check_field("present", 16'(want.present), 16'(rsp_present));
         check_field("hit_count", 16'(want.hit_count), 16'(rsp_hit_count));
         check_field("last", 16'(want.last), 16'(rsp_last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            byte_window[i] = 8'h00;
         end
         fresh_bytes = '0;
         last_accept_ms = '0;
         throttle = '0;
         expected_targets.delete();
      end else begin
         if (req_valid && !req_stall) begin
            absorb_byte(req_rx_byte, req_now_ms);
         end
         if (csr_valid && csr_ready) begin
            throttle = csr_throttle_ms;
         end
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
      end
      pending <= expected_targets.size();
      errors <= mismatches;
   end

endmodule

// ===== verif/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TARGETS = 3;
   localparam int FRAME_BYTES = 30;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES = 12;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic [31:0]        req_now_ms = 32'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_target_index;
   logic signed [15:0] rsp_pos_x;
   logic signed [15:0] rsp_pos_y;
   logic signed [15:0] rsp_velocity;
   logic [15:0]        rsp_res_word;
   logic               rsp_present;
   logic [1:0]         rsp_hit_count;
   logic               rsp_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [15:0]        csr_throttle_ms = 16'd0;

   int          errors;
   int          pending;
   int          quiet_cycles = 0;
   int          sent_bytes = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   logic [31:0] ms_clock = 32'd0;
   logic [7:0]  frame_buf [FRAME_BYTES];

   always #10 clock = ~clock;

   radar_target_frame_parser #(
      .TARGETS(TARGETS),
      .FRAME_BYTES(FRAME_BYTES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_target_index(rsp_target_index),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_velocity(rsp_velocity),
      .rsp_res_word(rsp_res_word),
      .rsp_present(rsp_present),
      .rsp_hit_count(rsp_hit_count),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_throttle_ms(csr_throttle_ms)
   );

   radar_frame_checker #(
      .TARGETS(TARGETS),
      .FRAME_BYTES(FRAME_BYTES)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_target_index(rsp_target_index),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_velocity(rsp_velocity),
      .rsp_res_word(rsp_res_word),
      .rsp_present(rsp_present),
      .rsp_hit_count(rsp_hit_count),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_throttle_ms(csr_throttle_ms),
      .errors(errors),
      .pending(pending)
   );

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      int wait_cycles;
      forever begin
         if ($urandom_range(0, 31) == 0) begin
            rsp_calm = !rsp_calm;
         end
         wait_cycles = rsp_calm ? 0 : $urandom_range(0, 7);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_byte(input logic [7:0] rx, input logic [31:0] now);
      int gap;
      if ($urandom_range(0, 31) == 0) begin
         req_calm = !req_calm;
      end
      gap = req_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      req_now_ms <= now;
      do @(posedge clock); while (req_stall);
      sent_bytes++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_throttle(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_throttle_ms <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] random_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 6))
         0: return rtfp_pkg::HDR0;
         1: return rtfp_pkg::HDR1;
         2: return rtfp_pkg::HDR2;
         3: return rtfp_pkg::HDR3;
         4: return rtfp_pkg::FTR0;
         5: return rtfp_pkg::FTR1;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void put_word(input int offset, input logic [15:0] word);
      frame_buf[offset] = word[7:0];
      frame_buf[offset + 1] = word[15:8];
   endfunction

   function automatic void fill_random_targets();
      int base;
      for (int i = 0; i < TARGETS; i++) begin
         base = rtfp_pkg::SLOT_BASE + rtfp_pkg::SLOT_BYTES * i;
         if ($urandom_range(0, 3) == 0) begin
            put_word(base, $urandom_range(0, 1) ? 16'h8000 : 16'h0000);
            put_word(base + 2, $urandom_range(0, 1) ? 16'h8000 : 16'h0000);
         end else begin
            put_word(base, random_word());
            put_word(base + 2, random_word());
         end
         put_word(base + 4, random_word());
         put_word(base + 6, 16'($urandom));
      end
   endfunction

   task automatic send_frame(input logic [31:0] close_ms, input int bad_pos, input int length);
      logic [7:0] rx;
      frame_buf[0] = rtfp_pkg::HDR0;
      frame_buf[1] = rtfp_pkg::HDR1;
      frame_buf[2] = rtfp_pkg::HDR2;
      frame_buf[3] = rtfp_pkg::HDR3;
      frame_buf[FRAME_BYTES - 2] = rtfp_pkg::FTR0;
      frame_buf[FRAME_BYTES - 1] = rtfp_pkg::FTR1;
      for (int k = 0; k < length; k++) begin
         rx = frame_buf[k];
         if (k == bad_pos) begin
            rx = rx ^ 8'($urandom_range(1, 255));
         end
         send_byte(rx, (k == FRAME_BYTES - 1) ? close_ms : $urandom);
      end
   endtask

   initial begin
      int start_bytes;
      int pick;
      int slot0;
      int slot1;
      int slot2;
      slot0 = rtfp_pkg::SLOT_BASE;
      slot1 = rtfp_pkg::SLOT_BASE + rtfp_pkg::SLOT_BYTES;
      slot2 = rtfp_pkg::SLOT_BASE + 2 * rtfp_pkg::SLOT_BYTES;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_throttle(16'd0);
      put_word(slot0, 16'hFFFF);
      put_word(slot0 + 2, 16'h7FFF);
      put_word(slot0 + 4, 16'h0000);
      put_word(slot0 + 6, 16'hFFFF);
      put_word(slot1, 16'h0000);
      put_word(slot1 + 2, 16'h8000);
      put_word(slot1 + 4, 16'h8000);
      put_word(slot1 + 6, 16'h0000);
      put_word(slot2, 16'h8000);
      put_word(slot2 + 2, 16'h0001);
      put_word(slot2 + 4, 16'h8001);
      put_word(slot2 + 6, 16'h00FF);
      send_frame($urandom, -1, FRAME_BYTES);

      // A header inside the payload must not be matched again until a full frame of new bytes.
      fill_random_targets();
      put_word(slot0, {rtfp_pkg::HDR1, rtfp_pkg::HDR0});
      put_word(slot0 + 2, {rtfp_pkg::HDR3, rtfp_pkg::HDR2});
      send_frame($urandom, -1, FRAME_BYTES);
      send_byte(8'($urandom), $urandom);
      send_byte(8'($urandom), $urandom);
      send_byte(rtfp_pkg::FTR0, $urandom);
      send_byte(rtfp_pkg::FTR1, $urandom);
      fill_random_targets();
      send_frame($urandom, -1, FRAME_BYTES);

      settle();
      write_throttle(16'd1);
      fill_random_targets();
      send_frame(32'd1000, -1, FRAME_BYTES);
      fill_random_targets();
      send_frame(32'd1000, -1, FRAME_BYTES);
      fill_random_targets();
      send_frame(32'd1001, -1, FRAME_BYTES);

      settle();
      write_throttle(16'd60000);
      fill_random_targets();
      send_frame(32'd61000, -1, FRAME_BYTES);
      fill_random_targets();
      send_frame(32'd61001, -1, FRAME_BYTES);
      fill_random_targets();
      send_frame(32'hFFFF_FFF0, -1, FRAME_BYTES);
      fill_random_targets();
      send_frame(32'd59900, -1, FRAME_BYTES);
      fill_random_targets();
      send_frame(32'd59984, -1, FRAME_BYTES);
      ms_clock = 32'd59984;

      for (int phase = 0; phase < 4; phase++) begin
         settle();
         write_throttle(phase == 0 ? 16'd0 : phase == 1 ? 16'd60000 :
                        phase == 2 ? 16'd1 : 16'($urandom_range(2, 59999)));
         start_bytes = sent_bytes;
         while (sent_bytes - start_bytes < PHASE_BYTES) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: ms_clock += $urandom_range(0, 200);
               4, 5, 6, 7: ms_clock += $urandom_range(50000, 70000);
               8: ms_clock = $urandom;
               default: ;
            endcase
            pick = $urandom_range(0, 19);
            fill_random_targets();
            if (pick < 14) begin
               send_frame(ms_clock, -1, FRAME_BYTES);
            end else if (pick < 16) begin
               pick = $urandom_range(0, 5);
               send_frame(ms_clock, (pick < 4) ? pick : FRAME_BYTES - 6 + pick, FRAME_BYTES);
            end else if (pick < 17) begin
               send_frame(ms_clock, -1, $urandom_range(4, 20));
            end else begin
               repeat ($urandom_range(1, 12)) send_byte(noise_byte(), $urandom);
            end
         end
      end

      settle();
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rtfp_pkg.sv
hw/rtl/rtfp_window.sv
hw/rtl/rtfp_drain.sv
hw/rtl/radar_target_frame_parser.sv
verif/radar_frame_checker.sv
verif/testbench.sv
